[design/srsw_pkg.sv]
package srsw_pkg;

   // Per-sequence status codes
   typedef enum logic [1:0] {
      ST_OUT    = 2'd0,
      ST_READY  = 2'd1,
      ST_RESEND = 2'd2,
      ST_ACKED  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      OP_START   = 2'd0,
      OP_SEND    = 2'd1,
      OP_ACK     = 2'd2,
      OP_TIMEOUT = 2'd3
   } op_type;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_MARK  = 5'b00010,
      S_READ  = 5'b00100,
      S_CHECK = 5'b01000,
      S_FIN   = 5'b10000
   } state_type;

   // Control bundle from the sequencer to the status store
   typedef struct packed {
      logic       clear;
      logic       wr_en;
      status_type wr_data;
   } store_req_type;

endpackage

[design/selective_repeat_sender_window.sv]
// Channel   Ports                                      Direction
// req       req_valid/req_ready, opcode, ack_byte      in
// rsp       rsp_valid/rsp_ready, send and count fields out
// csr       csr_wr_en, csr_wr_data (packet_total)      in, no wait
//
// One item at a time; req_ready is high only while the sequencer is idle.
// Per item: start clears the store; send scans from the base for a free entry
// within the window and the packets owed; ack marks an in-window entry and
// slides the base over the acked run; timeout scans min(WINDOW,SEQ_COUNT).
// Each scan step is one status-RAM read and one compare.
// Synchronous active-high reset: all entries ready, base/counts zero.
// A result waiting in the rsp register does not block the next transfer; only
// the final load stalls until that register is free.
module selective_repeat_sender_window import srsw_pkg::*; #(
   parameter int SEQ_COUNT = 20,
   parameter int WINDOW    = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [7:0]  req_ack_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_send_valid,
   output logic [4:0]  rsp_send_seq,
   output logic [15:0] rsp_packet_index,
   output logic [15:0] rsp_acked_count,
   output logic        rsp_transfer_done,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   localparam int SW   = $clog2(SEQ_COUNT);      // sequence index width
   localparam int CW   = $clog2(SEQ_COUNT + 1);  // scan counter width
   localparam int SPAN = (WINDOW < SEQ_COUNT) ? WINDOW : SEQ_COUNT;
   localparam logic [SW-1:0] LAST_IDX = SW'(SEQ_COUNT - 1);
   localparam logic [CW-1:0] SPAN_C   = CW'(SPAN);
   localparam logic [CW-1:0] SEQ_C    = CW'(SEQ_COUNT);

   // Sequencer state
   state_type     state_ff, state_in;
   op_type        op_ff, op_in;
   logic [SW-1:0] ptr_ff, ptr_in;       // scan pointer, walks from base
   logic [CW-1:0] cnt_ff, cnt_in;       // entries visited
   logic          ack_hit_ff, ack_hit_in;
   logic [SW-1:0] ack_idx_ff, ack_idx_in;

   // Window state
   logic [SW-1:0] base_ff, base_in;
   logic [15:0]   acked_ff, acked_in;
   logic [15:0]   left_ff, left_in;
   logic [15:0]   packet_total_ff;

   // Result being built
   logic          found_ff, found_in;
   logic [SW-1:0] seq_ff, seq_in;
   logic [15:0]   pidx_ff, pidx_in;

   // Output register
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_send_valid_ff, rsp_send_valid_in;
   logic [4:0]    rsp_send_seq_ff, rsp_send_seq_in;
   logic [15:0]   rsp_packet_index_ff, rsp_packet_index_in;
   logic [15:0]   rsp_acked_count_ff, rsp_acked_count_in;
   logic          rsp_transfer_done_ff, rsp_transfer_done_in;

   // Status store interface
   store_req_type st_req;
   logic [SW-1:0] st_wr_addr;
   status_type    st_q;

   logic          req_fire;
   logic [SW-1:0] ptr_next;
   logic [7:0]    ack_seq;
   logic [SW-1:0] ack_idx_c;
   logic [SW:0]   ack_dist;
   logic          ack_hit_c;
   logic          scan_done;
   logic [7:0]    seq_wide;

   srsw_store #(
      .SEQ_COUNT (SEQ_COUNT)
   ) u_store (
      .clock     (clock),
      .reset     (reset),
      .rd_addr   (ptr_ff),
      .wr_addr   (st_wr_addr),
      .req       (st_req),
      .rd_status (st_q)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign ptr_next  = (ptr_ff == LAST_IDX) ? '0 : ptr_ff + 1'b1;

   // Ack byte carries sequence plus one; distance from base taken mod SEQ_COUNT
   assign ack_seq   = req_ack_byte - 8'd1;
   assign ack_idx_c = ack_seq[SW-1:0];
   always_comb begin
      if (ack_idx_c >= base_ff) begin
         ack_dist = {1'b0, ack_idx_c} - {1'b0, base_ff};
      end else begin
         ack_dist = {1'b0, ack_idx_c} + (SW+1)'(SEQ_COUNT) - {1'b0, base_ff};
      end
   end
   assign ack_hit_c = (ack_seq < 8'(SEQ_COUNT)) && ((SW+2)'(ack_dist) < (SW+2)'(SPAN));

   // Scan bound: sends stop at the window or the packets still owed
   always_comb begin
      case (op_ff)
         OP_SEND: scan_done = (cnt_ff == SPAN_C) || (16'(cnt_ff) >= left_ff);
         OP_ACK:  scan_done = (cnt_ff == SEQ_C);
         default: scan_done = (cnt_ff == SPAN_C);
      endcase
   end

   assign seq_wide = 8'(seq_ff);

   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      ptr_in     = ptr_ff;
      cnt_in     = cnt_ff;
      ack_hit_in = ack_hit_ff;
      ack_idx_in = ack_idx_ff;
      base_in    = base_ff;
      acked_in   = acked_ff;
      left_in    = left_ff;
      found_in   = found_ff;
      seq_in     = seq_ff;
      pidx_in    = pidx_ff;

      rsp_valid_in         = rsp_valid_ff && !rsp_ready;
      rsp_send_valid_in    = rsp_send_valid_ff;
      rsp_send_seq_in      = rsp_send_seq_ff;
      rsp_packet_index_in  = rsp_packet_index_ff;
      rsp_acked_count_in   = rsp_acked_count_ff;
      rsp_transfer_done_in = rsp_transfer_done_ff;

      st_req     = '{clear: 1'b0, wr_en: 1'b0, wr_data: ST_READY};
      st_wr_addr = ptr_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in      = op_type'(req_opcode);
               ptr_in     = base_ff;
               cnt_in     = '0;
               found_in   = 1'b0;
               seq_in     = '0;
               pidx_in    = '0;
               ack_hit_in = ack_hit_c;
               ack_idx_in = ack_idx_c;
               unique case (op_type'(req_opcode))
                  OP_START: begin
                     st_req.clear = 1'b1;
                     base_in      = '0;
                     acked_in     = '0;
                     left_in      = packet_total_ff;
                     state_in     = S_FIN;
                  end
                  OP_ACK:  state_in = S_MARK;
                  OP_SEND, OP_TIMEOUT: state_in = S_READ;
               endcase
            end
         end
         S_MARK: begin
            if (ack_hit_ff) begin
               st_wr_addr     = ack_idx_ff;
               st_req.wr_en   = 1'b1;
               st_req.wr_data = ST_ACKED;
               state_in       = S_READ;
            end else begin
               state_in = S_FIN;
            end
         end
         S_READ: begin
            // ptr_ff is on the RAM address; data shows up in S_CHECK
            state_in = scan_done ? S_FIN : S_CHECK;
         end
         S_CHECK: begin
            case (op_ff)
               OP_SEND: begin
                  if (st_q == ST_READY || st_q == ST_RESEND) begin
                     st_req.wr_en   = 1'b1;
                     st_req.wr_data = ST_OUT;
                     found_in       = 1'b1;
                     seq_in         = ptr_ff;
                     pidx_in        = acked_ff + 16'(cnt_ff);
                     state_in       = S_FIN;
                  end else begin
                     ptr_in   = ptr_next;
                     cnt_in   = cnt_ff + 1'b1;
                     state_in = S_READ;
                  end
               end
               OP_ACK: begin
                  // slide base over in-order acked entries
                  if (st_q == ST_ACKED) begin
                     st_req.wr_en   = 1'b1;
                     st_req.wr_data = ST_READY;
                     base_in        = ptr_next;
                     if (acked_ff != 16'hFFFF) begin
                        acked_in = acked_ff + 16'd1;
                     end
                     if (left_ff != 16'd0) begin
                        left_in = left_ff - 16'd1;
                     end
                     ptr_in   = ptr_next;
                     cnt_in   = cnt_ff + 1'b1;
                     state_in = S_READ;
                  end else begin
                     state_in = S_FIN;
                  end
               end
               default: begin
                  if (st_q == ST_OUT) begin
                     st_req.wr_en   = 1'b1;
                     st_req.wr_data = ST_RESEND;
                  end
                  ptr_in   = ptr_next;
                  cnt_in   = cnt_ff + 1'b1;
                  state_in = S_READ;
               end
            endcase
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in         = 1'b1;
               rsp_send_valid_in    = found_ff;
               rsp_send_seq_in      = seq_wide[4:0];
               rsp_packet_index_in  = pidx_ff;
               rsp_acked_count_in   = acked_ff;
               rsp_transfer_done_in = (acked_ff == packet_total_ff);
               state_in             = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         rsp_valid_ff    <= 1'b0;
         base_ff         <= '0;
         acked_ff        <= '0;
         left_ff         <= '0;
         packet_total_ff <= 16'd1;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         base_ff      <= base_in;
         acked_ff     <= acked_in;
         left_ff      <= left_in;
         if (csr_wr_en) begin
            packet_total_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff                <= op_in;
      ptr_ff               <= ptr_in;
      cnt_ff               <= cnt_in;
      ack_hit_ff           <= ack_hit_in;
      ack_idx_ff           <= ack_idx_in;
      found_ff             <= found_in;
      seq_ff               <= seq_in;
      pidx_ff              <= pidx_in;
      rsp_send_valid_ff    <= rsp_send_valid_in;
      rsp_send_seq_ff      <= rsp_send_seq_in;
      rsp_packet_index_ff  <= rsp_packet_index_in;
      rsp_acked_count_ff   <= rsp_acked_count_in;
      rsp_transfer_done_ff <= rsp_transfer_done_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_send_valid    = rsp_send_valid_ff;
   assign rsp_send_seq      = rsp_send_seq_ff;
   assign rsp_packet_index  = rsp_packet_index_ff;
   assign rsp_acked_count   = rsp_acked_count_ff;
   assign rsp_transfer_done = rsp_transfer_done_ff;

   a_base_range: assert property (@(posedge clock) disable iff (reset)
      base_ff <= LAST_IDX)
      else $error("window base out of sequence range");

   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !st_req.wr_en)
      else $error("status write while idle");

   a_start_clears: assert property (@(posedge clock) disable iff (reset)
      req_fire && op_type'(req_opcode) == OP_START |=> base_ff == '0 && acked_ff == 16'd0)
      else $error("start did not clear window");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CHECK |-> cnt_ff < SEQ_C)
      else $error("scan ran past sequence space");

   a_fin_hold: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FIN && rsp_valid_ff && !rsp_ready |=> state_ff == S_FIN)
      else $error("result overwrote pending response");

endmodule

[design/srsw_ram.sv]
module srsw_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 20
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[design/srsw_store.sv]
module srsw_store import srsw_pkg::*; #(
   parameter int SEQ_COUNT = 20
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [$clog2(SEQ_COUNT)-1:0] rd_addr,
   input  logic [$clog2(SEQ_COUNT)-1:0] wr_addr,
   input  store_req_type                req,
   output status_type                   rd_status
);

   // Entry not yet written since reset or start reads as ready
   logic [SEQ_COUNT-1:0] valid_ff;
   logic [SEQ_COUNT-1:0] valid_in;
   logic                 rd_valid_ff;
   logic [1:0]           ram_q;

   srsw_ram #(
      .WIDTH (2),
      .DEPTH (SEQ_COUNT)
   ) u_ram (
      .clock   (clock),
      .wr_en   (req.wr_en),
      .wr_addr (wr_addr),
      .wr_data (req.wr_data),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   always_comb begin
      valid_in = valid_ff;
      if (req.clear) begin
         valid_in = '0;
      end else if (req.wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_status = rd_valid_ff ? status_type'(ram_q) : ST_READY;

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps

module testbench;
   import srsw_pkg::*;

   // Block geometry, matched to the uut parameters below
   localparam int SEQ_N  = 20;
   localparam int WIN_N  = 10;
   localparam int SCAN_N = (WIN_N < SEQ_N) ? WIN_N : SEQ_N;

   // Cycles with no transfer on either channel before the run is abandoned.
   localparam int IDLE_LIMIT = 2000;
   // Settle time after the last response before the final verdict
   localparam int DRAIN_CYCLES = 60;

   // One response transfer as seen on the rsp channel
   typedef struct {
      logic        send_valid;
      logic [4:0]  send_seq;
      logic [15:0] packet_index;
      logic [15:0] acked_count;
      logic        transfer_done;
   } window_result_type;

   // ------------------------------------------------------------------
   // Window tracker: own copy of the sender state, predicts the response
   // of every accepted request and checks responses in order.
   // ------------------------------------------------------------------
   class send_window_tracker;
      status_type        status [SEQ_N];
      int unsigned       base;
      int unsigned       acked;
      int unsigned       left;
      int unsigned       total;
      window_result_type pending_results [$];
      int                errors;

      function new();
         foreach (status[i]) status[i] = ST_READY;
         base   = 0;
         acked  = 0;
         left   = 0;
         total  = 1;
         errors = 0;
      endfunction

      task flag_mismatch(string msg);
         errors++;
         $display("[%0t] ERROR: %s", $realtime, msg);
      endtask

      task compare_field(string name, logic [31:0] got, logic [31:0] want);
         if (got !== want)
            flag_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
      endtask

      // Accepted request: advance the window state, queue the response
      function void note_request(op_type op, logic [7:0] ack_val);
         window_result_type r;
         int unsigned       n, s, d;
         logic              hit;
         r   = '{default: '0};
         hit = 1'b0;
         case (op)
            OP_START: begin
               foreach (status[i]) status[i] = ST_READY;
               base  = 0;
               acked = 0;
               left  = total;
            end
            OP_SEND: begin
               // scan bounded by window and by packets still to go
               n = (left < SCAN_N) ? left : SCAN_N;
               for (int i = 0; i < n; i++) begin
                  s = (base + i) % SEQ_N;
                  if (!hit && (status[s] == ST_READY || status[s] == ST_RESEND)) begin
                     hit            = 1'b1;
                     status[s]      = ST_OUT;
                     r.send_valid   = 1'b1;
                     r.send_seq     = 5'(s);
                     r.packet_index = 16'(acked + i);
                  end
               end
            end
            OP_ACK: begin
               s = (ack_val + 255) & 8'hFF;   // byte 0 lands on 255, never a seq
               if (s < SEQ_N) begin
                  d = (s + SEQ_N - base) % SEQ_N;
                  if (d < SCAN_N) begin
                     status[s] = ST_ACKED;
                     // slide over the acked run at the base
                     for (int i = 0; i < SEQ_N; i++) begin
                        if (!hit && status[base] == ST_ACKED) begin
                           status[base] = ST_READY;
                           base = (base + 1) % SEQ_N;
                           if (acked < 16'hFFFF) acked++;
                           if (left > 0) left--;
                        end else begin
                           hit = 1'b1;
                        end
                     end
                  end
               end
            end
            default: begin
               for (int i = 0; i < SCAN_N; i++) begin
                  s = (base + i) % SEQ_N;
                  if (status[s] == ST_OUT) status[s] = ST_RESEND;
               end
            end
         endcase
         r.acked_count   = 16'(acked);
         r.transfer_done = (acked == total);
         pending_results.push_back(r);
      endfunction

      task check_response(window_result_type got);
         window_result_type want;
         if (pending_results.size() == 0) begin
            flag_mismatch("response with no request outstanding");
         end else begin
            want = pending_results.pop_front();
            compare_field("send_valid", 32'(got.send_valid), 32'(want.send_valid));
            compare_field("send_seq", 32'(got.send_seq), 32'(want.send_seq));
            compare_field("packet_index", 32'(got.packet_index),
                          32'(want.packet_index));
            compare_field("acked_count", 32'(got.acked_count), 32'(want.acked_count));
            compare_field("transfer_done", 32'(got.transfer_done),
                          32'(want.transfer_done));
         end
      endtask
   endclass

   // ------------------------------------------------------------------
   // DUT signals, all inputs known from time zero
   // ------------------------------------------------------------------
   logic        clock        = 1'b0;
   logic        reset        = 1'b1;
   logic        req_valid    = 1'b0;
   logic        req_ready;
   logic [1:0]  req_opcode   = OP_START;
   logic [7:0]  req_ack_byte = 8'd0;
   logic        rsp_valid;
   logic        rsp_ready    = 1'b0;
   logic        rsp_send_valid;
   logic [4:0]  rsp_send_seq;
   logic [15:0] rsp_packet_index;
   logic [15:0] rsp_acked_count;
   logic        rsp_transfer_done;
   logic        csr_wr_en    = 1'b0;
   logic [15:0] csr_wr_data  = 16'd0;

   send_window_tracker tracker = new();

   // Traffic shaping
   int burst_left = 0;     // requests left in the current sender burst
   bit fast_mode  = 1'b0;  // no gaps, no stalls (closing back-to-back run)
   int rx_mode    = 0;
   int rx_left    = 0;
   int rx_count   = 0;
   int idle_count = 0;

   selective_repeat_sender_window #(
      .SEQ_COUNT(SEQ_N),
      .WINDOW   (WIN_N)
   ) uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_ack_byte     (req_ack_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_send_valid   (rsp_send_valid),
      .rsp_send_seq     (rsp_send_seq),
      .rsp_packet_index (rsp_packet_index),
      .rsp_acked_count  (rsp_acked_count),
      .rsp_transfer_done(rsp_transfer_done),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Monitor: everything sampled at the rising edge. Response is checked
   // before the request of the same edge is noted; a response always
   // belongs to an older request.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      window_result_type got;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            got.send_valid    = rsp_send_valid;
            got.send_seq      = rsp_send_seq;
            got.packet_index  = rsp_packet_index;
            got.acked_count   = rsp_acked_count;
            got.transfer_done = rsp_transfer_done;
            tracker.check_response(got);
         end
         if (req_valid && req_ready)
            tracker.note_request(op_type'(req_opcode), req_ack_byte);
      end
   end

   // Watchdog: any transfer on either channel resets the count
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_count <= 0;
      end else if (idle_count >= IDLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         idle_count <= idle_count + 1;
      end
   end

   // Receiver backpressure: a mode held for a random stretch -- always
   // ready, coin flip, one-in-four, or mostly stalled
   always @(negedge clock) begin
      logic rx_next;
      if (rx_left == 0) begin
         rx_mode = $urandom_range(0, 3);
         rx_left = $urandom_range(20, 200);
      end
      rx_left--;
      rx_count++;
      case (rx_mode)
         0:       rx_next = 1'b1;
         1:       rx_next = 1'($urandom_range(0, 1));
         2:       rx_next = (rx_count % 4 == 0);
         default: rx_next = ($urandom_range(0, 7) == 0);
      endcase
      rsp_ready = fast_mode ? 1'b1 : rx_next;
   end

   // ------------------------------------------------------------------
   // Driver tasks, entered and left at a falling edge
   // ------------------------------------------------------------------

   // One request transfer; bursts of back-to-back requests with random
   // gaps in between. Valid is only lowered for a real gap.
   task automatic drive_item(op_type op, logic [7:0] ack_val);
      int gap;
      if (!fast_mode && burst_left == 0) begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         burst_left = $urandom_range(1, 24);
         if (gap > 0) begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      if (burst_left > 0) burst_left--;
      req_valid    = 1'b1;
      req_opcode   = op;
      req_ack_byte = ack_val;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Wait until every queued response has come back; the block is idle then
   task automatic drain_results();
      req_valid = 1'b0;
      while (tracker.pending_results.size() != 0) @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   // packet_total write, only with the block idle
   task automatic write_total(logic [15:0] value);
      drain_results();
      csr_wr_en   = 1'b1;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en     = 1'b0;
      tracker.total = value;
   endtask

   // Ack byte for the entry at a given distance from the base
   function automatic logic [7:0] ack_at(int offset);
      return 8'(((tracker.base + offset) % SEQ_N) + 1);
   endfunction

   // Mostly protocol-like traffic: sends, acks of outstanding entries,
   // timeouts; the rest is noise bytes, acks outside the window, restarts.
   task automatic pick_item(output op_type op, output logic [7:0] ack_val);
      int roll, first, off;
      bit found;
      roll    = $urandom_range(0, 99);
      ack_val = 8'($urandom_range(0, 255));
      found   = 1'b0;
      if (roll < 40) begin
         op = OP_SEND;
      end else if (roll < 72) begin
         op    = OP_ACK;
         first = $urandom_range(0, SCAN_N - 1);
         for (int i = 0; i < SCAN_N; i++) begin
            off = (first + i) % SCAN_N;
            if (!found && tracker.status[(tracker.base + off) % SEQ_N] == ST_OUT) begin
               found   = 1'b1;
               ack_val = ack_at(off);
            end
         end
         if (!found) ack_val = ack_at($urandom_range(0, SCAN_N - 1));
      end else if (roll < 80) begin
         op = OP_ACK;      // raw byte: mostly out of range, sometimes 0
         if ($urandom_range(0, 3) == 0) ack_val = 8'd0;
      end else if (roll < 85) begin
         op      = OP_ACK; // valid seq but beyond the window
         ack_val = ack_at($urandom_range(SCAN_N, SEQ_N - 1));
      end else if (roll < 98) begin
         op = OP_TIMEOUT;
      end else begin
         op = OP_START;
      end
   endtask

   task automatic run_random(int count);
      op_type     op;
      logic [7:0] ack_val;
      for (int k = 0; k < count; k++) begin
         pick_item(op, ack_val);
         drive_item(op, ack_val);
      end
   endtask

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      int          totals [10];
      int          seq_base;
      logic [15:0] phase_total;

      totals = '{2, 9, 10, 11, 19, 20, 21, 37, 150, 65535};

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed, packet_total still at its reset value of 1.
      // Before any start nothing can be sent.
      drive_item(OP_SEND, 8'hA5);
      drive_item(OP_TIMEOUT, 8'h5A);
      drive_item(OP_ACK, 8'd0);      // wraps to 255: ignored
      drive_item(OP_ACK, 8'd1);      // slides even with no packets left
      drive_item(OP_START, 8'hFF);
      drive_item(OP_SEND, 8'h00);    // seq 0
      drive_item(OP_SEND, 8'h00);    // bounded by one packet left: none
      drive_item(OP_TIMEOUT, 8'h00); // seq 0 -> resend
      drive_item(OP_SEND, 8'h00);    // seq 0 again
      drive_item(OP_ACK, 8'd255);
      drive_item(OP_ACK, 8'd21);     // seq 20, past the sequence space
      drive_item(OP_ACK, 8'd1);      // done

      // Directed, twelve packets: out-of-order acks and resend
      write_total(16'd12);
      drive_item(OP_START, 8'h00);
      drive_item(OP_SEND, 8'h00);
      drive_item(OP_SEND, 8'h00);
      drive_item(OP_SEND, 8'h00);
      drive_item(OP_ACK, 8'd3);      // seq 2, out of order
      drive_item(OP_ACK, 8'd16);     // seq 15, outside the window
      drive_item(OP_ACK, 8'd5);      // seq 4, never sent but still acked
      drive_item(OP_ACK, 8'd1);      // base slides one
      drive_item(OP_ACK, 8'd2);      // base slides over 1 and 2
      drive_item(OP_SEND, 8'h00);
      drive_item(OP_TIMEOUT, 8'h00);
      drive_item(OP_SEND, 8'h00);    // resend of the timed-out entry
      drive_item(OP_SEND, 8'h00);

      // Random phases over a spread of packet totals, each from a fresh start
      for (int p = 0; p < 12; p++) begin
         phase_total = (p < 10) ? 16'(totals[p]) : 16'($urandom_range(1, 64));
         write_total(phase_total);
         drive_item(OP_START, 8'($urandom_range(0, 255)));
         run_random(150);
      end

      // Back-to-back full-window acks with no stalls, highest first; the
      // last ack, at the base, slides ten entries at once
      write_total(16'hFFFF);
      fast_mode = 1'b1;
      drive_item(OP_START, 8'h00);
      for (int round = 0; round < 2; round++) begin
         seq_base = tracker.base;
         for (int j = SCAN_N - 1; j >= 0; j--)
            drive_item(OP_ACK, 8'(((seq_base + j) % SEQ_N) + 1));
      end
      drive_item(OP_SEND, 8'h00);
      drive_item(OP_TIMEOUT, 8'h00);
      drive_item(OP_SEND, 8'h00);
      fast_mode = 1'b0;

      // Wind down and give the block time to show any stray response
      drain_results();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (tracker.pending_results.size() != 0)
         tracker.flag_mismatch($sformatf("%0d responses never arrived",
                                         tracker.pending_results.size()));
      if (tracker.errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

[files.f]
design/srsw_pkg.sv
design/srsw_ram.sv
design/srsw_store.sv
design/selective_repeat_sender_window.sv
tb/testbench.sv
